### src/lzss_pkg.sv
package lzss_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 4096;

  localparam logic [7:0] TYPE_BYTE = 8'h10;
  localparam logic [4:0] LEN_BIAS  = 5'd3;
  localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_TYPE = 2'd1;
  localparam logic [1:0] ST_DIST = 2'd2;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_SIZE0,
    PH_SIZE1,
    PH_SIZE2,
    PH_BODY,
    PH_TOKEN2,
    PH_DONE
  } lzss_phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COPY_RD,
    S_COPY_WR
  } lzss_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_stream;
  } lzss_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
    logic [1:0] status;
  } lzss_out_t;

endpackage

### src/lzss_ram.sv
module lzss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/lzss_stream_decompressor_core.sv
// LZ77 type 0x10 stream decoder. Compressed bytes enter one per input transfer; each
// header byte, flag byte, first token byte or literal is taken when the result register
// is free, and a literal's result is registered at its transfer. The second byte of a
// match token starts a copy sequencer that, for each output byte, reads the history
// RAM, whose read data is registered, then sends the byte and writes it back once the
// result register is free, so a token holds off the next input until its last byte is
// sent. A type byte other than 0x10 gives one error result and decoding goes on.
// Copies stop at the declared size; a distance that reaches before the stream start
// marks every byte of that token with status 2 and sends 0 for the missing source bytes.
module lzss_stream_decompressor_core #(
  parameter int unsigned WINDOW_DEPTH = lzss_pkg::WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lzss_pkg::lzss_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lzss_pkg::lzss_out_t out_data
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned DW = AW + 1;

  lzss_pkg::lzss_state_t state_r, state_nxt;
  lzss_pkg::lzss_phase_t phase_r, phase_nxt;

  logic [23:0] bw_r, bw_nxt;
  logic [23:0] total_r, total_nxt;
  logic [7:0]  flag_bits_r, flag_bits_nxt;
  logic [3:0]  flags_left_r, flags_left_nxt;
  logic [7:0]  tok_r, tok_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [4:0]  left_r, left_nxt;
  logic [12:0] dist_r, dist_nxt;
  logic [1:0]  st_r, st_nxt;

  logic                out_valid_r, out_valid_nxt;
  lzss_pkg::lzss_out_t out_data_r, out_data_nxt;

  logic          slot_free;
  logic          in_xfer;
  lzss_pkg::lzss_phase_t eff_phase;
  logic [23:0]   bw_inc;
  logic          size_hit;
  logic [AW-1:0] wp_inc;
  logic [AW-1:0] rp_inc;
  logic [4:0]    tok_len;
  logic [12:0]   tok_dist;
  logic [23:0]   room;
  logic [DW-1:0] rp_diff;
  logic          src_ok;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == lzss_pkg::S_IDLE) && slot_free;
  assign in_xfer   = in_valid && in_ready;
  assign eff_phase = in_data.start_of_stream ? lzss_pkg::PH_TYPE : phase_r;

  assign bw_inc   = bw_r + 24'd1;
  assign size_hit = (bw_inc >= total_r);
  assign wp_inc   = (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + AW'(1);
  assign rp_inc   = (rp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : rp_r + AW'(1);

  // token fields come from the stored first byte and the byte now arriving
  assign tok_len  = {1'b0, tok_r[7:4]} + lzss_pkg::LEN_BIAS;
  assign tok_dist = {tok_r[3:0], in_data.in_byte} + 13'd1;
  assign room     = total_r - bw_r;
  // source pointer wraps back into the window when it goes negative
  assign rp_diff  = {1'b0, wp_r} - DW'(tok_dist);
  assign src_ok   = ({11'd0, dist_r} <= bw_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lzss_pkg::S_IDLE;
      phase_r      <= lzss_pkg::PH_TYPE;
      bw_r         <= '0;
      total_r      <= '0;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      tok_r        <= '0;
      wp_r         <= '0;
      left_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      bw_r         <= bw_nxt;
      total_r      <= total_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      tok_r        <= tok_nxt;
      wp_r         <= wp_nxt;
      left_r       <= left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r       <= rp_nxt;
    dist_r     <= dist_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    bw_nxt         = bw_r;
    total_nxt      = total_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    tok_nxt        = tok_r;
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    left_nxt       = left_r;
    dist_nxt       = dist_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = wp_r;
    ram_wdata      = in_data.in_byte;
    ram_re         = 1'b0;

    case (state_r)
      lzss_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (eff_phase)
            lzss_pkg::PH_TYPE: begin
              bw_nxt         = '0;
              total_nxt      = '0;
              flag_bits_nxt  = '0;
              flags_left_nxt = '0;
              tok_nxt        = '0;
              wp_nxt         = '0;
              phase_nxt      = lzss_pkg::PH_SIZE0;
              if (in_data.in_byte != lzss_pkg::TYPE_BYTE) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{out_byte: 8'd0, last_of_run: 1'b1, stream_done: 1'b0,
                                  status: lzss_pkg::ST_TYPE};
              end
            end
            lzss_pkg::PH_SIZE0: begin
              total_nxt = {16'd0, in_data.in_byte};
              phase_nxt = lzss_pkg::PH_SIZE1;
            end
            lzss_pkg::PH_SIZE1: begin
              total_nxt = {8'd0, in_data.in_byte, total_r[7:0]};
              phase_nxt = lzss_pkg::PH_SIZE2;
            end
            lzss_pkg::PH_SIZE2: begin
              total_nxt = {in_data.in_byte, total_r[15:0]};
              phase_nxt = ({in_data.in_byte, total_r[15:0]} == 24'd0) ?
                          lzss_pkg::PH_DONE : lzss_pkg::PH_BODY;
            end
            lzss_pkg::PH_BODY: begin
              if (flags_left_r == 4'd0) begin
                flag_bits_nxt  = in_data.in_byte;
                flags_left_nxt = lzss_pkg::FLAGS_PER_BYTE;
              end else begin
                flag_bits_nxt  = {flag_bits_r[6:0], 1'b0};
                flags_left_nxt = flags_left_r - 4'd1;
                if (flag_bits_r[7]) begin
                  tok_nxt   = in_data.in_byte;
                  phase_nxt = lzss_pkg::PH_TOKEN2;
                end else begin
                  // literal
                  ram_we        = 1'b1;
                  bw_nxt        = bw_inc;
                  wp_nxt        = wp_inc;
                  out_valid_nxt = 1'b1;
                  out_data_nxt  = '{out_byte: in_data.in_byte, last_of_run: 1'b1,
                                    stream_done: size_hit, status: lzss_pkg::ST_OK};
                  if (size_hit) begin
                    phase_nxt = lzss_pkg::PH_DONE;
                  end
                end
              end
            end
            lzss_pkg::PH_TOKEN2: begin
              phase_nxt = lzss_pkg::PH_BODY;
              dist_nxt  = tok_dist;
              st_nxt    = ({11'd0, tok_dist} > bw_r) ? lzss_pkg::ST_DIST : lzss_pkg::ST_OK;
              left_nxt  = (room < {19'd0, tok_len}) ? room[4:0] : tok_len;
              rp_nxt    = rp_diff[DW-1] ? AW'(rp_diff + DW'(WINDOW_DEPTH)) : rp_diff[AW-1:0];
              state_nxt = lzss_pkg::S_COPY_RD;
            end
            default: begin
            end
          endcase
        end
      end
      lzss_pkg::S_COPY_RD: begin
        ram_re    = 1'b1;
        state_nxt = lzss_pkg::S_COPY_WR;
      end
      lzss_pkg::S_COPY_WR: begin
        if (slot_free) begin
          ram_we        = 1'b1;
          ram_wdata     = src_ok ? ram_rdata : 8'd0;
          bw_nxt        = bw_inc;
          wp_nxt        = wp_inc;
          rp_nxt        = rp_inc;
          left_nxt      = left_r - 5'd1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: src_ok ? ram_rdata : 8'd0,
                            last_of_run: (left_r == 5'd1), stream_done: size_hit,
                            status: st_r};
          if (size_hit) begin
            phase_nxt = lzss_pkg::PH_DONE;
          end
          state_nxt = (left_r == 5'd1) ? lzss_pkg::S_IDLE : lzss_pkg::S_COPY_RD;
        end
      end
      default: begin
        state_nxt = lzss_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/lzss_checker.sv
module lzss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lzss_pkg::lzss_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a match run blocks new input until its last byte is out
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |-> !in_ready)
    else $error("input taken in the middle of a match run");

  // completion always ends the run
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_done |-> out_data.last_of_run)
    else $error("stream done on a non-final result");

  // type error result is a lone zero byte
  a_type_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == lzss_pkg::ST_TYPE |->
      out_data.out_byte == 8'd0 && out_data.last_of_run && !out_data.stream_done)
    else $error("malformed type error result");

  // a type error can only follow an input transfer
  a_type_err_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_data.status == lzss_pkg::ST_TYPE |->
      $past(in_valid && in_ready))
    else $error("type error without an input transfer");

endmodule

bind lzss_stream_decompressor_core lzss_checker u_lzss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/lzss_stream_decompressor_core_tb.sv
module lzss_stream_decompressor_core_tb;

  localparam int unsigned WIN = lzss_pkg::WINDOW_DEPTH_DEF;
  localparam int unsigned WIN_AW = $clog2(WIN);
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  lzss_pkg::lzss_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  lzss_pkg::lzss_out_t out_data;

  lzss_stream_decompressor_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // decoder state mirrored on the testbench side
  logic [7:0]            history_mem [0:WIN-1];
  logic [23:0]           dec_written;
  logic [23:0]           dec_size;
  lzss_pkg::lzss_phase_t dec_phase;
  logic [7:0]            dec_flags;
  logic [3:0]            dec_flags_left;
  logic [7:0]            dec_token_b0;

  lzss_pkg::lzss_out_t expected_out [$];
  int unsigned         mismatch_count;
  int unsigned         items_sent;
  int unsigned         cycle_count;
  int unsigned         hold_left;
  bit                  tx_idle_on;
  bit                  rx_idle_on;
  bit                  hold_req;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  task automatic report_error(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic emit_byte(input logic [7:0] v, input logic [1:0] st);
    lzss_pkg::lzss_out_t r;
    history_mem[WIN_AW'(dec_written % WIN)] = v;
    dec_written = dec_written + 24'd1;
    r.out_byte = v;
    r.last_of_run = 1'b0;
    r.stream_done = (dec_written >= dec_size);
    r.status = st;
    if (r.stream_done) dec_phase = lzss_pkg::PH_DONE;
    expected_out.push_back(r);
  endtask

  // works out the results caused by one compressed byte
  task automatic decode_byte(input logic [7:0] b, input logic sos);
    int unsigned         len;
    int unsigned         match_dist;
    int unsigned         room;
    int unsigned         i;
    int unsigned         n_before;
    logic [1:0]          st;
    logic [7:0]          v;
    logic                bit_is_token;
    lzss_pkg::lzss_out_t r;
    n_before = expected_out.size();
    if (sos) dec_phase = lzss_pkg::PH_TYPE;
    case (dec_phase)
      lzss_pkg::PH_TYPE: begin
        dec_written = '0;
        dec_size = '0;
        dec_flags = '0;
        dec_flags_left = '0;
        dec_token_b0 = '0;
        if (b != lzss_pkg::TYPE_BYTE) begin
          r.out_byte = 8'h00;
          r.last_of_run = 1'b0;
          r.stream_done = 1'b0;
          r.status = lzss_pkg::ST_TYPE;
          expected_out.push_back(r);
        end
        dec_phase = lzss_pkg::PH_SIZE0;
      end
      lzss_pkg::PH_SIZE0: begin
        dec_size = {16'h0000, b};
        dec_phase = lzss_pkg::PH_SIZE1;
      end
      lzss_pkg::PH_SIZE1: begin
        dec_size[15:8] = b;
        dec_phase = lzss_pkg::PH_SIZE2;
      end
      lzss_pkg::PH_SIZE2: begin
        dec_size[23:16] = b;
        dec_phase = (dec_size == 24'd0) ? lzss_pkg::PH_DONE : lzss_pkg::PH_BODY;
      end
      lzss_pkg::PH_BODY: begin
        if (dec_flags_left == 4'd0) begin
          dec_flags = b;
          dec_flags_left = lzss_pkg::FLAGS_PER_BYTE;
        end else begin
          bit_is_token = dec_flags[7];
          dec_flags = dec_flags << 1;
          dec_flags_left = dec_flags_left - 4'd1;
          if (bit_is_token) begin
            dec_token_b0 = b;
            dec_phase = lzss_pkg::PH_TOKEN2;
          end else begin
            emit_byte(b, lzss_pkg::ST_OK);
          end
        end
      end
      lzss_pkg::PH_TOKEN2: begin
        len = 32'(dec_token_b0[7:4]) + 32'(lzss_pkg::LEN_BIAS);
        match_dist = 32'({dec_token_b0[3:0], b}) + 1;
        room = 32'(dec_size) - 32'(dec_written);
        st = (match_dist > 32'(dec_written)) ? lzss_pkg::ST_DIST : lzss_pkg::ST_OK;
        dec_phase = lzss_pkg::PH_BODY;
        if (len > room) len = room;
        for (i = 0; i < len; i++) begin
          // source bytes before the stream start read as zero
          v = (match_dist <= 32'(dec_written)) ?
              history_mem[WIN_AW'((32'(dec_written) - match_dist) % WIN)] : 8'h00;
          emit_byte(v, st);
        end
      end
      default: ;
    endcase
    if (expected_out.size() > n_before) begin
      r = expected_out.pop_back();
      r.last_of_run = 1'b1;
      expected_out.push_back(r);
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic sos);
    lzss_pkg::lzss_in_t item;
    item.in_byte = b;
    item.start_of_stream = sos;
    if (tx_idle_on) begin
      while ($urandom_range(0, 99) < 6) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, sos);
    items_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
  endtask

  // header, flag groups of literals and tokens up to size or cut_at bytes, then junk
  task automatic send_stream(input int unsigned size, input int unsigned token_pct,
                             input int unsigned bad_dist_pct, input bit all_long,
                             input bit bad_type, input int unsigned cut_at,
                             input int unsigned junk);
    int unsigned made;
    int unsigned len;
    int unsigned match_dist;
    int unsigned lim;
    int unsigned k;
    logic [7:0]  flags;
    logic [7:0]  type_b;
    logic [11:0] dcode;
    logic [3:0]  lcode;
    logic [23:0] sz;
    sz = 24'(size);
    type_b = lzss_pkg::TYPE_BYTE;
    if (bad_type) begin
      type_b = 8'($urandom_range(0, 255));
      if (type_b == lzss_pkg::TYPE_BYTE) type_b = ~lzss_pkg::TYPE_BYTE;
    end
    send_item(type_b, 1'b1);
    send_item(sz[7:0], 1'b0);
    send_item(sz[15:8], 1'b0);
    send_item(sz[23:16], 1'b0);
    made = 0;
    while (made < size && made < cut_at) begin
      for (k = 0; k < 8; k++) flags[k] = ($urandom_range(0, 99) < token_pct);
      send_item(flags, 1'b0);
      for (k = 0; k < 8 && made < size && made < cut_at; k++) begin
        if (flags[7 - k]) begin
          len = all_long ? 18 : $urandom_range(3, 18);
          lim = (made < WIN) ? made : WIN;
          if (lim == 0 || (lim < WIN && $urandom_range(0, 99) < bad_dist_pct))
            match_dist = $urandom_range(lim + 1, WIN);
          else if ($urandom_range(0, 9) == 0)
            match_dist = lim;
          else
            match_dist = $urandom_range(1, lim);
          dcode = 12'(match_dist - 1);
          lcode = 4'(len - 3);
          send_item({lcode, dcode[11:8]}, 1'b0);
          send_item(dcode[7:0], 1'b0);
          made += (len < size - made) ? len : size - made;
        end else begin
          send_item(8'($urandom_range(0, 255)), 1'b0);
          made++;
        end
      end
    end
    repeat (junk) send_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic test_headerless_empty_stream();
    // type byte taken without start flag, zero size, then a byte that is ignored
    send_item(lzss_pkg::TYPE_BYTE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
  endtask

  task automatic test_bad_type_and_bad_distance();
    send_item(8'h00, 1'b1);
    send_item(8'h05, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h50, 1'b0);
    send_item(8'ha5, 1'b0);
    // distance 2 with one byte written: partly before the stream start
    send_item(8'h00, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h5a, 1'b0);
    send_item(8'hff, 1'b0);
  endtask

  task automatic test_restart_mid_token();
    send_item(lzss_pkg::TYPE_BYTE, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h30, 1'b0);
    send_item(lzss_pkg::TYPE_BYTE, 1'b1);
    send_item(8'h04, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h40, 1'b0);
    send_item(8'hff, 1'b0);
    // longest token at distance one, clipped at the declared size
    send_item(8'hf0, 1'b0);
    send_item(8'h00, 1'b0);
  endtask

  task automatic test_random_streams();
    int unsigned first;
    int unsigned pick;
    int unsigned size;
    int unsigned cut;
    first = items_sent;
    while (items_sent - first < 60) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        repeat ($urandom_range(1, 6))
          send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        if (pick < 80) size = $urandom_range(1, 60);
        else if (pick < 95) size = $urandom_range(61, 400);
        else size = $urandom_range(1000, 24'hffffff);
        cut = size;
        if (size > 400) cut = $urandom_range(20, 80);
        else if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, size - 1);
        send_stream(size, $urandom_range(20, 80), 10, 1'b0, $urandom_range(0, 99) < 8, cut,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
      end
    end
  endtask

  task automatic test_window_wrap();
    // long output so that copies reach across the history wraparound
    send_stream(4300, 90, 0, 1'b1, 1'b0, 4300, 2);
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_stream(120, 50, 10, 1'b0, 1'b0, 120, 0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    hold_req = 1'b1;
    send_stream(150, 60, 5, 1'b0, 1'b0, 150, 0);
  endtask

  task automatic test_drain_pause();
    wait_for_drain();
    send_stream(40, 50, 10, 1'b0, 1'b0, 40, 0);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        hold_left = 500;
        while (hold_left != 0) begin
          @(posedge clk);
          hold_left--;
        end
      end
      out_ready <= !(rx_idle_on && $urandom_range(0, 99) < 6);
    end
  end

  always @(posedge clk) begin
    lzss_pkg::lzss_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        report_error($sformatf("result %02h with nothing expected", out_data.out_byte));
      end else begin
        want = expected_out.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_error($sformatf("out_byte %02h, want %02h", out_data.out_byte, want.out_byte));
        if (out_data.last_of_run !== want.last_of_run)
          report_error($sformatf("last_of_run %b, want %b", out_data.last_of_run,
                                 want.last_of_run));
        if (out_data.stream_done !== want.stream_done)
          report_error($sformatf("stream_done %b, want %b", out_data.stream_done,
                                 want.stream_done));
        if (out_data.status !== want.status)
          report_error($sformatf("status %0d, want %0d", out_data.status, want.status));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req = 1'b0;
    mismatch_count = 0;
    items_sent = 0;
    dec_written = '0;
    dec_size = '0;
    dec_phase = lzss_pkg::PH_TYPE;
    dec_flags = '0;
    dec_flags_left = '0;
    dec_token_b0 = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_headerless_empty_stream();
    test_bad_type_and_bad_distance();
    test_restart_mid_token();
    test_random_streams();
    test_window_wrap();
    test_back_to_back();
    test_output_hold();
    test_drain_pause();
    in_valid <= 1'b0;
    wait_for_drain();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
src/lzss_pkg.sv
src/lzss_ram.sv
src/lzss_stream_decompressor_core.sv
src/lzss_checker.sv
tb/lzss_stream_decompressor_core_tb.sv
